// File: rtl/prrs_pkg.sv
// Package: shared constants, types and codes for the priority round-robin scheduler.
`default_nettype none
package prrs_pkg;
	localparam int NUM_LEVELS = 8;
	localparam int DEQUE_DEPTH = 16;
	localparam int THREAD_ID_BITS = 6;
	localparam int LV_W = $clog2(NUM_LEVELS);
	localparam int POS_W = $clog2(DEQUE_DEPTH);
	localparam int LEN_W = $clog2(DEQUE_DEPTH + 1);
	localparam int CNT_W = $clog2(DEQUE_DEPTH + 2);
	localparam int ADDR_W = LV_W + POS_W;
	localparam int PRIO_W = 8;
	localparam int STAT_W = 3;

	typedef logic [THREAD_ID_BITS-1:0] tid_t;
	typedef logic [LV_W-1:0] lv_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {
		FN_ADD = 2'd0,
		FN_WAIT = 2'd1,
		FN_WAKE = 2'd2,
		FN_SELECT = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK = 3'd0,
		ST_BAD_PRIO = 3'd1,
		ST_EMPTY = 3'd2,
		ST_FULL = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	// datapath commands
	typedef struct packed {
		logic load;       // latch request, reset scan state
		logic scan_next;  // advance select scan level
		logic rd_issue;   // read store at head plus search position
		logic pos_inc;    // advance search position
		logic do_add;
		logic do_wake;
		logic cur_clear;  // wait hit current slot
		logic shift_wr;   // write shifted entry at pos-1
		logic rem_done;   // finish removal
		logic sel_rot;    // select rotation with popped front
		logic set_result;
		logic [STAT_W-1:0] res_status;
		logic res_chosen_cur; // chosen = current of scan level
		logic res_chosen_rd;  // chosen = read data
		logic res_idle;
		logic push_old;   // write old current at back
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic bad_prio;
		logic full;
		logic cnt_zero;
		logic cur_match;
		logic pos_end;     // search pos reached length
		logic rd_match;
		logic scan_cnt_nz;
		logic scan_len_nz;
		logic scan_cur_v;
		logic scan_last;
	} stat_t;
endpackage
`default_nettype wire

// File: rtl/prrs_datapath.sv
// Datapath: level state, ready store memory and result register.
`default_nettype none
module prrs_datapath (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire prrs_pkg::cmd_t cmd,
	output prrs_pkg::stat_t st,
	input  wire logic [1:0] in_func,
	input  wire prrs_pkg::tid_t in_tid,
	input  wire logic [prrs_pkg::PRIO_W-1:0] in_prio,
	input  wire prrs_pkg::tid_t idle_tid,
	output prrs_pkg::tid_t res_chosen,
	output logic res_idle,
	output logic [prrs_pkg::STAT_W-1:0] res_status
);
	import prrs_pkg::*;

	tid_t store_mem [NUM_LEVELS*DEQUE_DEPTH];
	pos_t head_q [NUM_LEVELS];
	len_t qlen_q [NUM_LEVELS];
	cnt_t cnt_q [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] curv_q;
	tid_t curid_q [NUM_LEVELS];

	func_t func_q;
	tid_t tid_q;
	lv_t lv_q;
	logic bad_q;
	len_t pos_q;
	tid_t rd_q;

	pos_t head_l;
	len_t len_l;
	addr_t rd_addr, wr_addr;
	tid_t wr_data;
	logic wr_en;
	pos_t back_pos;

	assign head_l = head_q[lv_q];
	assign len_l = qlen_q[lv_q];
	assign rd_addr = {lv_q, POS_W'(head_l + pos_q[POS_W-1:0])};
	assign back_pos = POS_W'(head_l + POS_W'(len_l));

	always_comb begin
		wr_en = 1'b0;
		wr_addr = rd_addr;
		wr_data = tid_q;
		if (cmd.do_add) begin
			wr_en = 1'b1;
			wr_addr = {lv_q, POS_W'(head_l - POS_W'(1))};
		end else if (cmd.do_wake) begin
			wr_en = 1'b1;
			wr_addr = {lv_q, back_pos};
		end else if (cmd.shift_wr) begin
			wr_en = 1'b1;
			wr_addr = {lv_q, POS_W'(head_l + pos_q[POS_W-1:0] - POS_W'(1))};
			wr_data = rd_q;
		end else if (cmd.push_old) begin
			wr_en = 1'b1;
			wr_addr = {lv_q, back_pos};
			wr_data = curid_q[lv_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) store_mem[wr_addr] <= wr_data;
		if (cmd.rd_issue) rd_q <= store_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(in_func);
			tid_q <= in_tid;
			lv_q <= (in_func == FN_SELECT) ? '0 : lv_t'(in_prio);
			bad_q <= in_prio >= PRIO_W'(NUM_LEVELS);
		end else if (cmd.scan_next) begin
			lv_q <= lv_t'(lv_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				qlen_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			curv_q <= '0;
			pos_q <= '0;
			res_chosen <= '0;
			res_idle <= 1'b0;
			res_status <= '0;
		end else begin
			if (cmd.load) pos_q <= '0;
			if (cmd.pos_inc) pos_q <= LEN_W'(pos_q + 1'b1);
			if (cmd.do_add) begin
				head_q[lv_q] <= POS_W'(head_l - POS_W'(1));
				qlen_q[lv_q] <= LEN_W'(len_l + 1'b1);
				cnt_q[lv_q] <= CNT_W'(cnt_q[lv_q] + 1'b1);
			end
			if (cmd.do_wake) begin
				qlen_q[lv_q] <= LEN_W'(len_l + 1'b1);
				cnt_q[lv_q] <= CNT_W'(cnt_q[lv_q] + 1'b1);
			end
			if (cmd.cur_clear) begin
				curv_q[lv_q] <= 1'b0;
				cnt_q[lv_q] <= CNT_W'(cnt_q[lv_q] - 1'b1);
			end
			if (cmd.rem_done) begin
				qlen_q[lv_q] <= LEN_W'(len_l - 1'b1);
				cnt_q[lv_q] <= CNT_W'(cnt_q[lv_q] - 1'b1);
			end
			if (cmd.sel_rot) begin
				head_q[lv_q] <= POS_W'(head_l + POS_W'(1));
				if (!curv_q[lv_q]) qlen_q[lv_q] <= LEN_W'(len_l - 1'b1);
				curv_q[lv_q] <= 1'b1;
			end
			if (cmd.set_result) begin
				res_status <= cmd.res_status;
				res_idle <= cmd.res_idle;
				if (cmd.res_chosen_rd) res_chosen <= rd_q;
				else if (cmd.res_chosen_cur) res_chosen <= curid_q[lv_q];
				else if (cmd.res_idle) res_chosen <= idle_tid;
				else res_chosen <= '0;
			end
		end
	end

	// curid_q has no reset: undefined until written
	always_ff @(posedge clk) begin
		if (cmd.sel_rot) curid_q[lv_q] <= rd_q;
	end

	always_comb begin
		st.func = func_q;
		st.bad_prio = bad_q;
		st.full = len_l >= LEN_W'(DEQUE_DEPTH);
		st.cnt_zero = cnt_q[lv_q] == '0;
		st.cur_match = curv_q[lv_q] && (curid_q[lv_q] == tid_q);
		st.pos_end = pos_q >= len_l;
		st.rd_match = rd_q == tid_q;
		st.scan_cnt_nz = cnt_q[lv_q] != '0;
		st.scan_len_nz = len_l != '0;
		st.scan_cur_v = curv_q[lv_q];
		st.scan_last = lv_q == lv_t'(NUM_LEVELS - 1);
	end
endmodule
`default_nettype wire

// File: rtl/prrs_ctrl.sv
// Controller: sequencer for add, wait, wake and select operations.
`default_nettype none
module prrs_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	input  wire prrs_pkg::stat_t st,
	output prrs_pkg::cmd_t cmd
);
	import prrs_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_DECODE = 10'b0000000010,
		S_SRD    = 10'b0000000100,
		S_SCHK   = 10'b0000001000,
		S_MRD    = 10'b0000010000,
		S_MWR    = 10'b0000100000,
		S_SCAN   = 10'b0001000000,
		S_POP    = 10'b0010000000,
		S_PUSH   = 10'b0100000000,
		S_OUT    = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (st.func == FN_SELECT) begin
					state_d = S_SCAN;
				end else if (st.bad_prio) begin
					cmd.set_result = 1'b1;
					cmd.res_status = ST_BAD_PRIO;
					state_d = S_OUT;
				end else if (st.func == FN_WAIT) begin
					if (st.cnt_zero) begin
						cmd.set_result = 1'b1;
						cmd.res_status = ST_EMPTY;
						state_d = S_OUT;
					end else if (st.cur_match) begin
						cmd.cur_clear = 1'b1;
						cmd.set_result = 1'b1;
						cmd.res_status = ST_OK;
						state_d = S_OUT;
					end else begin
						state_d = S_SRD;
					end
				end else if (st.full) begin
					cmd.set_result = 1'b1;
					cmd.res_status = ST_FULL;
					state_d = S_OUT;
				end else begin
					cmd.do_add = (st.func == FN_ADD);
					cmd.do_wake = (st.func == FN_WAKE);
					cmd.set_result = 1'b1;
					cmd.res_status = ST_OK;
					state_d = S_OUT;
				end
			end
			S_SRD: begin
				if (st.pos_end) begin
					cmd.set_result = 1'b1;
					cmd.res_status = ST_NOT_FOUND;
					state_d = S_OUT;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d = S_SCHK;
				end
			end
			S_SCHK: begin
				cmd.pos_inc = 1'b1;
				state_d = st.rd_match ? S_MRD : S_SRD;
			end
			S_MRD: begin
				if (st.pos_end) begin
					cmd.rem_done = 1'b1;
					cmd.set_result = 1'b1;
					cmd.res_status = ST_OK;
					state_d = S_OUT;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d = S_MWR;
				end
			end
			S_MWR: begin
				cmd.shift_wr = 1'b1;
				cmd.pos_inc = 1'b1;
				state_d = S_MRD;
			end
			S_SCAN: begin
				if (st.scan_cnt_nz && st.scan_len_nz) begin
					cmd.rd_issue = 1'b1;
					state_d = S_POP;
				end else if (st.scan_cnt_nz && st.scan_cur_v) begin
					cmd.set_result = 1'b1;
					cmd.res_chosen_cur = 1'b1;
					cmd.res_status = ST_OK;
					state_d = S_OUT;
				end else if (st.scan_last) begin
					cmd.set_result = 1'b1;
					cmd.res_idle = 1'b1;
					cmd.res_status = ST_OK;
					state_d = S_OUT;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			S_POP: begin
				cmd.set_result = 1'b1;
				cmd.res_chosen_rd = 1'b1;
				cmd.res_status = ST_OK;
				if (st.scan_cur_v) begin
					state_d = S_PUSH;
				end else begin
					cmd.sel_rot = 1'b1;
					state_d = S_OUT;
				end
			end
			S_PUSH: begin
				// write old current at back (head still unmoved, len unchanged)
				cmd.push_old = 1'b1;
				cmd.sel_rot = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

`ifndef SYNTHESIS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_fire) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.do_add, cmd.do_wake, cmd.shift_wr, cmd.push_old}) <= 1)
		else $error("store write conflict");
`endif
endmodule
`default_nettype wire

// File: rtl/priority_round_robin_scheduler_unit.sv
// Top level: priority round-robin scheduler with stream ports and idle-thread register.
//
// channel | dir | handshake          | payload
// s_axis  | in  | tvalid/tready      | tdata: func, thread_id, priority_req
// m_axis  | out | tvalid/tready      | tdata: chosen_thread, chosen_is_idle, status
// cfg     | in  | cfg_valid/cfg_ready| cfg_data: idle_thread
//
// One word at a time. Wait searches the level's deque and then shifts the later entries
// down through the single store write port; select scans levels upward, one level scanned per cycle.
// Reset clears all level counts; no clearing pass. A stalled result holds s_axis_tready low.
`default_nettype none
module priority_round_robin_scheduler_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [15:0] s_axis_tdata, // func[1:0], thread_id[7:2], priority_req[15:8]
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [15:0] m_axis_tdata, // chosen_thread[5:0], chosen_is_idle[6], status[9:7]
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [prrs_pkg::THREAD_ID_BITS-1:0] cfg_data
);
	import prrs_pkg::*;

	cmd_t cmd;
	stat_t st;
	tid_t idle_q;
	tid_t res_chosen;
	logic res_idle;
	logic [STAT_W-1:0] res_status;
	logic in_fire;

	assign cfg_ready = 1'b1;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) idle_q <= '0;
		else if (cfg_valid) idle_q <= cfg_data;
	end

	prrs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .st(st), .cmd(cmd)
	);

	prrs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.in_func(s_axis_tdata[1:0]), .in_tid(s_axis_tdata[7:2]),
		.in_prio(s_axis_tdata[15:8]), .idle_tid(idle_q),
		.res_chosen(res_chosen), .res_idle(res_idle), .res_status(res_status)
	);

	assign m_axis_tdata = {6'd0, res_status, res_idle, res_chosen};
endmodule
`default_nettype wire

// File: tb/tb.sv
// Testbench: scheduler operations checked against an inline predictor over stream ports.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import prrs_pkg::*;

	typedef struct packed {
		logic [2:0] status;
		logic idle;
		logic [5:0] chosen;
	} sched_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [THREAD_ID_BITS-1:0] cfg_data = '0;

	priority_round_robin_scheduler_unit dut (.*);

	always #5 clk = ~clk;

	// predictor state
	tid_t idle_tid;
	tid_t deq [NUM_LEVELS][$];
	logic cur_v [NUM_LEVELS];
	tid_t cur_id [NUM_LEVELS];

	logic [15:0] pending_words [$];
	sched_result_t expected_results [$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	task automatic report(input string msg);
		$display("tb: mismatch: %s", msg);
		errors++;
	endtask

	function automatic sched_result_t predict(input logic [15:0] w);
		sched_result_t r;
		func_t f;
		tid_t t;
		logic [7:0] p;
		int lv;
		int idx;
		r = '0;
		f = func_t'(w[1:0]);
		t = w[7:2];
		p = w[15:8];
		if (f == FN_SELECT) begin
			r.idle = 1'b1;
			r.chosen = idle_tid;
			for (lv = 0; lv < NUM_LEVELS; lv++) begin
				if (deq[lv].size() > 0) begin
					r.chosen = deq[lv].pop_front();
					if (cur_v[lv])
						deq[lv].push_back(cur_id[lv]);
					cur_id[lv] = r.chosen;
					cur_v[lv] = 1'b1;
					r.idle = 1'b0;
					break;
				end
				if (cur_v[lv]) begin
					r.chosen = cur_id[lv];
					r.idle = 1'b0;
					break;
				end
			end
		end else if (p >= NUM_LEVELS) begin
			r.status = ST_BAD_PRIO;
		end else begin
			lv = p;
			if (f == FN_WAIT) begin
				if (deq[lv].size() == 0 && !cur_v[lv]) begin
					r.status = ST_EMPTY;
				end else if (cur_v[lv] && cur_id[lv] == t) begin
					cur_v[lv] = 1'b0;
				end else begin
					idx = -1;
					foreach (deq[lv][i])
						if (idx < 0 && deq[lv][i] == t)
							idx = i;
					if (idx < 0)
						r.status = ST_NOT_FOUND;
					else
						deq[lv].delete(idx);
				end
			end else if (deq[lv].size() >= DEQUE_DEPTH) begin
				r.status = ST_FULL;
			end else if (f == FN_ADD) begin
				deq[lv].push_front(t);
			end else begin
				deq[lv].push_back(t);
			end
		end
		return r;
	endfunction

	function automatic logic [15:0] make_word(input func_t f, input int t, input int p);
		return {p[7:0], t[5:0], f};
	endfunction

	function automatic logic [15:0] rand_word();
		int k;
		int lv;
		k = $urandom_range(0, 99);
		lv = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
		if (k < 30)
			return make_word(FN_SELECT, $urandom_range(0, 63), $urandom_range(0, 255));
		if (k < 50)
			return make_word(FN_ADD, $urandom_range(0, 15), lv);
		if (k < 72)
			return make_word(FN_WAKE, $urandom_range(0, 15), lv);
		return make_word(FN_WAIT, $urandom_range(0, 15), lv);
	endfunction

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			expected_results.push_back(predict(s_axis_tdata));
			void'(pending_words.pop_front());
		end
		if ((!s_axis_tvalid || s_axis_tready) && pending_words.size() > 0 && arst_n) begin
			if ($urandom_range(0, 99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_words[0];
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end else if (s_axis_tvalid && s_axis_tready) begin
			s_axis_tvalid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		sched_result_t got;
		sched_result_t exp_r;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[9:0];
			if (expected_results.size() == 0) begin
				report($sformatf("unexpected word %h", m_axis_tdata));
			end else begin
				exp_r = expected_results.pop_front();
				if (got.chosen !== exp_r.chosen)
					report($sformatf("chosen %0d exp %0d", got.chosen, exp_r.chosen));
				if (got.idle !== exp_r.idle)
					report($sformatf("idle %0b exp %0b", got.idle, exp_r.idle));
				if (got.status !== exp_r.status)
					report($sformatf("status %0d exp %0d", got.status, exp_r.status));
				if (m_axis_tdata[15:10] !== '0)
					report($sformatf("pad bits %h", m_axis_tdata));
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic drain();
		while (pending_words.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (4 + 2 * DEQUE_DEPTH + 10) @(posedge clk);
	endtask

	task automatic write_idle(input int v);
		cfg_valid <= 1'b1;
		cfg_data <= v[5:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		idle_tid = v[5:0];
	endtask

	initial begin
		int lv;
		idle_tid = '0;
		for (lv = 0; lv < NUM_LEVELS; lv++)
			cur_v[lv] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed
		pending_words.push_back(make_word(FN_SELECT, 63, 255));
		pending_words.push_back(make_word(FN_WAIT, 5, 2));
		pending_words.push_back(make_word(FN_ADD, 63, 255));
		pending_words.push_back(make_word(FN_WAKE, 1, 8));
		pending_words.push_back(make_word(FN_WAIT, 1, 128));
		pending_words.push_back(make_word(FN_ADD, 63, 7));
		pending_words.push_back(make_word(FN_WAKE, 0, 7));
		pending_words.push_back(make_word(FN_WAIT, 9, 7));
		pending_words.push_back(make_word(FN_SELECT, 0, 0));
		pending_words.push_back(make_word(FN_SELECT, 0, 0));
		pending_words.push_back(make_word(FN_WAIT, 63, 7));
		pending_words.push_back(make_word(FN_WAIT, 0, 7));
		pending_words.push_back(make_word(FN_SELECT, 0, 0));
		pending_words.push_back(make_word(FN_ADD, 42, 0));
		pending_words.push_back(make_word(FN_SELECT, 0, 0));
		pending_words.push_back(make_word(FN_SELECT, 0, 0));
		for (int i = 0; i < 17; i++)
			pending_words.push_back(make_word(FN_WAKE, 21, 3));
		pending_words.push_back(make_word(FN_ADD, 22, 3));
		pending_words.push_back(make_word(FN_WAIT, 42, 0));
		pending_words.push_back(make_word(FN_WAIT, 42, 0));
		drain();
		write_idle(63);
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 56; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 56; end
				3: begin send_idle_pct = 34; recv_stall_pct = 34; end
				default: begin send_idle_pct = 0; recv_stall_pct = 10; end
			endcase
			if (ph == 4)
				hold_cycles = 300;
			for (int i = 0; i < 200; i++)
				pending_words.push_back(rand_word());
			drain();
			write_idle(ph == 2 ? 0 : $urandom_range(0, 63));
			for (int i = 0; i < 8; i++)
				pending_words.push_back(make_word(FN_SELECT, 0, 0));
			drain();
		end
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
